// File: rtl/core/mpd_pkg.sv
`timescale 1ns / 1ps
package mpd_pkg;

  localparam int unsigned NumChannelsDefault  = 4;
  localparam int unsigned CordicStagesDefault = 16;
  localparam int unsigned TableLen            = 24;
  localparam int unsigned SampleW             = 16;
  localparam int unsigned PhaseW              = 16;
  // x, y carry the sample times 256 plus CORDIC growth
  localparam int unsigned XyW                 = 27;
  localparam int unsigned ZW                  = 26;
  localparam logic signed [ZW-1:0] Deg90Z     = 26'sd5898240;
  localparam logic signed [PhaseW-1:0] HalfTurn = 16'sd23040;
  localparam logic signed [PhaseW:0]   FullTurn = 17'sd46080;

  typedef struct packed {
    logic signed [SampleW-1:0] ch3_q;
    logic signed [SampleW-1:0] ch3_i;
    logic signed [SampleW-1:0] ch2_q;
    logic signed [SampleW-1:0] ch2_i;
    logic signed [SampleW-1:0] ch1_q;
    logic signed [SampleW-1:0] ch1_i;
    logic signed [SampleW-1:0] ch0_q;
    logic signed [SampleW-1:0] ch0_i;
  } in_req_t;

  typedef struct packed {
    logic signed [PhaseW-1:0] diff3;
    logic signed [PhaseW-1:0] diff2;
    logic signed [PhaseW-1:0] diff1;
    logic signed [PhaseW-1:0] diff0;
  } out_req_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] k);
    logic signed [ZW-1:0] r;
    unique case (k)
      5'd0: r = 26'sd2949120;  5'd1: r = 26'sd1740967;
      5'd2: r = 26'sd919879;   5'd3: r = 26'sd466945;
      5'd4: r = 26'sd234379;   5'd5: r = 26'sd117304;
      5'd6: r = 26'sd58666;    5'd7: r = 26'sd29335;
      5'd8: r = 26'sd14668;    5'd9: r = 26'sd7334;
      5'd10: r = 26'sd3667;    5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;     5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;     5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;       5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;       default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/multichannel_phase_difference.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// in        in   in_valid_i/in_stall_o  in_req_t (chK_i, chK_q)
// out       out  out_valid_o/out_stall_i out_req_t (diff0..diff3)
// One request per cycle sustained while the output is not stalled; pipe registers:
// entry register, one per CORDIC stage, rounding, wrap.
// The whole pipe advances when the output is free; in_stall_o follows out stall.
// Reset clears only the valid bits; asynchronous, active low.
module multichannel_phase_difference import mpd_pkg::*; #(
  parameter int unsigned CordicStages = CordicStagesDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  localparam int unsigned NumCh = NumChannelsDefault;
  localparam int unsigned NSt = (CordicStages > TableLen) ? TableLen : CordicStages;
  localparam int unsigned Depth = NSt + 3;

  logic en;
  logic [Depth-1:0] vld_q;
  logic signed [SampleW-1:0] si [NumCh];
  logic signed [SampleW-1:0] sq [NumCh];
  logic signed [PhaseW-1:0]  ph [NumCh];
  out_req_t res_q;

  assign en         = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o = !en;

  assign si[0] = in_req_i.ch0_i; assign sq[0] = in_req_i.ch0_q;
  assign si[1] = in_req_i.ch1_i; assign sq[1] = in_req_i.ch1_q;
  assign si[2] = in_req_i.ch2_i; assign sq[2] = in_req_i.ch2_q;
  assign si[3] = in_req_i.ch3_i; assign sq[3] = in_req_i.ch3_q;

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    mpd_cordic #(.CordicStages(CordicStages)) u_cordic (
      .clk_i   (clk_i),
      .en_i    (en),
      .i_i     (si[c]),
      .q_i     (sq[c]),
      .phase_o (ph[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  function automatic logic signed [PhaseW-1:0] wrap(
    input logic signed [PhaseW-1:0] p, input logic signed [PhaseW-1:0] r);
    logic signed [PhaseW:0] d;
    d = {p[PhaseW-1], p} - {r[PhaseW-1], r};
    if (d > (PhaseW+1)'(HalfTurn))       d = d - FullTurn;
    else if (d < -(PhaseW+1)'(HalfTurn)) d = d + FullTurn;
    return d[PhaseW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q.diff0 <= '0;
      res_q.diff1 <= wrap(ph[1], ph[0]);
      res_q.diff2 <= wrap(ph[2], ph[0]);
      res_q.diff3 <= wrap(ph[3], ph[0]);
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign out_req_o   = res_q;

endmodule

// File: rtl/core/mpd_cordic.sv
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC, one rotation per stage; advances when en_i.
module mpd_cordic import mpd_pkg::*; #(
  parameter int unsigned CordicStages = CordicStagesDefault
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [SampleW-1:0] i_i,
  input  logic signed [SampleW-1:0] q_i,
  output logic signed [PhaseW-1:0]  phase_o
);

  localparam int unsigned NSt = (CordicStages > TableLen) ? TableLen : CordicStages;

  logic signed [XyW-1:0] x_q [NSt+1];
  logic signed [XyW-1:0] y_q [NSt+1];
  logic signed [ZW-1:0]  z_q [NSt+1];
  logic                  zero_q [NSt+1];
  logic signed [PhaseW-1:0] phase_q;

  logic signed [XyW-1:0] x0, y0;
  logic signed [ZW-1:0]  z0;

  always_comb begin
    logic signed [XyW-1:0] xs, ys;
    xs = XyW'(i_i) <<< 8;
    ys = XyW'(q_i) <<< 8;
    x0 = xs; y0 = ys; z0 = '0;
    if (i_i < 0) begin
      if (q_i >= 0) begin
        x0 = ys; y0 = -xs; z0 = Deg90Z;
      end else begin
        x0 = -ys; y0 = xs; z0 = -Deg90Z;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      z_q[0]    <= z0;
      zero_q[0] <= (i_i == 0) && (q_i == 0);
    end
  end

  for (genvar k = 0; k < NSt; k++) begin : g_st
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[k+1] <= zero_q[k];
        if (y_q[k] > 0) begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + atan_lut(5'(k));
        end else begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - atan_lut(5'(k));
        end
      end
    end
  end

  logic signed [ZW-1:0] zr;
  logic signed [PhaseW-1:0] pd;
  always_comb begin
    zr = (z_q[NSt] + ZW'(256)) >>> 9;
    if (zr > ZW'(HalfTurn))       pd = HalfTurn;
    else if (zr < -ZW'(HalfTurn)) pd = -HalfTurn;
    else                          pd = PhaseW'(zr);
    if (zero_q[NSt]) pd = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phase_q <= pd;
    end
  end

  assign phase_o = phase_q;

endmodule
